/* design/dnm_pkg.sv */
`timescale 1ns / 1ps

package dnm_pkg;

  localparam int VALUE_W    = 31;
  localparam int PATTERN_W  = 5;
  localparam int DIGIT_W    = 4;
  localparam int MAX_DIGITS = 10;
  localparam int BCD_W      = DIGIT_W * MAX_DIGITS;
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W      = $clog2(VALUE_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } dnm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dnm_conv_stat_t;

  // Morse digit: 0..5 dots then dashes, 6..9 dashes then dots (1 = dash)
  function automatic logic [PATTERN_W-1:0] pattern_of(input logic [DIGIT_W-1:0] d);
    logic [PATTERN_W-1:0] p;
    case (d)
      4'd0:    p = 5'b11111;
      4'd1:    p = 5'b01111;
      4'd2:    p = 5'b00111;
      4'd3:    p = 5'b00011;
      4'd4:    p = 5'b00001;
      4'd5:    p = 5'b00000;
      4'd6:    p = 5'b10000;
      4'd7:    p = 5'b11000;
      4'd8:    p = 5'b11100;
      4'd9:    p = 5'b11110;
      default: p = 5'b11111;
    endcase
    return p;
  endfunction

endpackage

/* design/dnm_in_if.sv */
`timescale 1ns / 1ps

interface dnm_in_if;
  logic                          valid;
  logic                          ready;
  logic [dnm_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* design/dnm_out_if.sv */
`timescale 1ns / 1ps

interface dnm_out_if;
  logic                            valid;
  logic                            ready;
  logic [dnm_pkg::PATTERN_W-1:0]   pattern;
  logic [dnm_pkg::DIGIT_W-1:0]     digit;
  logic                            last;

  modport source (output valid, output pattern, output digit, output last, input ready);
  modport sink   (input valid, input pattern, input digit, input last, output ready);
endinterface

/* design/dnm_bcd_conv.sv */
`timescale 1ns / 1ps

// Shift-and-add-3 binary to BCD, one input bit per cycle.
module dnm_bcd_conv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dnm_pkg::VALUE_W-1:0]   value,
  output logic [dnm_pkg::BCD_W-1:0]     bcd,
  output dnm_pkg::dnm_conv_stat_t       stat
);

  logic [dnm_pkg::VALUE_W-1:0] bin;
  logic [dnm_pkg::CNT_W-1:0]   cnt;
  logic                        busy;
  logic                        done;
  logic [dnm_pkg::BCD_W-1:0]   corr;

  always_comb begin
    for (int i = 0; i < dnm_pkg::MAX_DIGITS; i++) begin
      if (bcd[i*dnm_pkg::DIGIT_W +: dnm_pkg::DIGIT_W] >= 4'd5) begin
        corr[i*dnm_pkg::DIGIT_W +: dnm_pkg::DIGIT_W] =
          bcd[i*dnm_pkg::DIGIT_W +: dnm_pkg::DIGIT_W] + 4'd3;
      end else begin
        corr[i*dnm_pkg::DIGIT_W +: dnm_pkg::DIGIT_W] =
          bcd[i*dnm_pkg::DIGIT_W +: dnm_pkg::DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == dnm_pkg::CNT_W'(dnm_pkg::VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // top digit's carry falls off, which keeps the value mod 10^MAX_DIGITS
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[dnm_pkg::VALUE_W-2:0], 1'b0};
      bcd <= {corr[dnm_pkg::BCD_W-2:0], bin[dnm_pkg::VALUE_W-1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* design/decimal_number_to_morse.sv */
`timescale 1ns / 1ps

// Channel  Dir  Beat payload
// din      in   value[30:0]
// dout     out  pattern[4:0], digit[3:0], last
//
// A number is accepted, then runs 31 shift-and-add-3 steps in the BCD
// unit, then ten digit slots (leading zeros skipped one per cycle, each
// emitted digit one beat); stalls on dout hold back the digit beats.
// din is ready only while idle. The last digit beat sits in the output
// register, so a new number is taken while it waits.
// rst is synchronous and clears the sequencer and output valid.
module decimal_number_to_morse (
  input  logic      clk,
  input  logic      rst,
  dnm_in_if.sink    din,
  dnm_out_if.source dout
);

  dnm_pkg::dnm_state_t          state;
  dnm_pkg::dnm_state_t          state_next;
  logic [dnm_pkg::IDX_W-1:0]    idx;
  logic                         started;
  logic [dnm_pkg::BCD_W-1:0]    bcd;
  dnm_pkg::dnm_conv_stat_t      stat;
  logic                         in_beat;
  logic [dnm_pkg::DIGIT_W-1:0]  cur_digit;
  logic                         skip;
  logic                         load;
  logic                         out_valid;
  logic [dnm_pkg::PATTERN_W-1:0] out_pattern;
  logic [dnm_pkg::DIGIT_W-1:0]  out_digit;
  logic                         out_last;

  assign in_beat   = din.valid && din.ready;
  assign cur_digit = bcd[idx*dnm_pkg::DIGIT_W +: dnm_pkg::DIGIT_W];

  dnm_bcd_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (in_beat),
    .value (din.value),
    .bcd   (bcd),
    .stat  (stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      dnm_pkg::S_IDLE: if (in_beat) state_next = dnm_pkg::S_CONV;
      dnm_pkg::S_CONV: if (stat.done) state_next = dnm_pkg::S_EMIT;
      dnm_pkg::S_EMIT: if (load && idx == '0) state_next = dnm_pkg::S_IDLE;
      default:         state_next = dnm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    din.ready = 1'b0;
    skip      = 1'b0;
    load      = 1'b0;
    case (state)
      dnm_pkg::S_IDLE: din.ready = 1'b1;
      dnm_pkg::S_EMIT: begin
        if (!started && cur_digit == '0 && idx != '0) begin
          skip = 1'b1;
        end else begin
          load = !out_valid || dout.ready;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dnm_pkg::S_IDLE;
      idx       <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (stat.done) begin
        idx     <= dnm_pkg::IDX_W'(dnm_pkg::MAX_DIGITS - 1);
        started <= 1'b0;
      end else if (skip || load) begin
        idx <= idx - 1'b1;
        if (load) started <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pattern <= dnm_pkg::pattern_of(cur_digit);
      out_digit   <= cur_digit;
      out_last    <= (idx == '0);
    end
  end

  assign dout.valid   = out_valid;
  assign dout.pattern = out_pattern;
  assign dout.digit   = out_digit;
  assign dout.last    = out_last;

`ifndef SYNTH
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.digit <= 4'd9)
    else $error("digit out of range");

  a_pattern_match: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.pattern == dnm_pkg::pattern_of(dout.digit))
    else $error("pattern does not match digit");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == dnm_pkg::S_CONV)
    else $error("conversion finished outside CONV");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> stat.busy)
    else $error("BCD unit not started");
`endif

endmodule
